FILE: sv/afa_pkg.sv
// ----------------------------------------------------------------------------
// afa_pkg
// Shared widths, constants and the arctangent table of the flow angle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package afa_pkg;

  // Number of vectoring iterations, limited to the length of the table.
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_ITER     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam int SPEED_W     = 32;
  localparam int ANGLE_W     = 16;
  localparam int MIN_SPEED_W = 31;
  localparam int MAG_W       = SPEED_W + 1;
  localparam int GUARD_BITS  = 24;
  // Magnitude times the CORDIC gain stays below 2^57 after the guard shift.
  localparam int XY_W        = MAG_W + GUARD_BITS + 2;
  localparam int Z_W         = 34;
  localparam int ATAN_W      = 30;
  localparam int PI_W        = 32;
  localparam int PROD_W      = Z_W + PI_W;
  localparam int ROUND_SHIFT = 47;
  localparam int RES_W       = PROD_W - ROUND_SHIFT;

  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [MIN_SPEED_W-1:0] MIN_SPEED_RST = MIN_SPEED_W'(655);

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_MIN_SPEED = 1'b0;

  // Values of the func field.
  localparam logic FUNC_AOA      = 1'b0;
  localparam logic FUNC_SIDESLIP = 1'b1;

  // Binary angle units: one turn is 2^32.
  localparam logic signed [Z_W-1:0]     QUARTER_TURN = Z_W'(64'sd1073741824);
  localparam logic signed [PI_W-1:0]    PI_Q29       = PI_W'(64'sd1686629713);
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT  = ANGLE_W'(32'sd25736);

  localparam logic [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
    30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
    30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
    30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

endpackage

`default_nettype wire

FILE: sv/afa_in_if.sv
// ----------------------------------------------------------------------------
// afa_in_if
// Input channel: mode and two signed Q16.16 velocity components.
// ----------------------------------------------------------------------------
`default_nettype none

interface afa_in_if import afa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [SPEED_W-1:0] y_speed;
  logic signed [SPEED_W-1:0] x_speed;

  modport source (output valid, output func, output y_speed, output x_speed,
                  input ready);
  modport sink   (input valid, input func, input y_speed, input x_speed,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/afa_out_if.sv
// ----------------------------------------------------------------------------
// afa_out_if
// Result channel: flow angle in Q3.13 radians and the low speed flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface afa_out_if import afa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  logic                      too_slow;

  modport source (output valid, output angle, output too_slow, input ready);
  modport sink   (input valid, input angle, input too_slow, output ready);
endinterface

`default_nettype wire

FILE: sv/aero_flow_angle_atan2.sv
// ----------------------------------------------------------------------------
// aero_flow_angle_atan2
// Angle of attack or sideslip from two velocity components by CORDIC.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while its stages are not stalled, and
// returns one result word for each, in order. The pipeline has one entry
// stage for the magnitude test and quadrant turn, one register stage per
// vectoring iteration, one for the angle scaling multiplier and one for the
// rounding and saturation that feeds the output register. Each stage holds
// its word only while the stages after it are full and the sink is stalled,
// so input is still taken while a result waits, as long as a stage is free.
// min_speed sits at byte address 0 of the APB port; the user must see that it
// is written only while the unit is empty, as the block does not enforce it.
`default_nettype none

module aero_flow_angle_atan2 import afa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  afa_in_if.sink                  in_if,
  afa_out_if.source               out_if,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  // Stages 0..NUM_ITER carry x, y, z; then the product stage and the output.
  localparam int PROD_ST = NUM_ITER + 1;
  localparam int OUT_ST  = NUM_ITER + 2;
  localparam int NS      = NUM_ITER + 3;

  localparam logic signed [RES_W-1:0]  LIM_HI    = RES_W'(ANGLE_LIMIT);
  localparam logic signed [RES_W-1:0]  LIM_LO    = -LIM_HI;
  localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(1) <<< (ROUND_SHIFT - 1);

  // ---------------------------------------------------------------- config
  logic [MIN_SPEED_W-1:0] min_speed_q;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_SPEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q <= MIN_SPEED_RST;
    end else if (cfg_wr) begin
      min_speed_q <= pwdata[MIN_SPEED_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_SPEED) begin
      prdata = DATA_W'(min_speed_q);
    end
  end

  // ------------------------------------------------------------ flow control
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  // A stage may load when it or any stage after it is empty, or the sink takes.
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      en[s] = out_if.ready ||
              ((~vld_q & ~((NS'(1) << s) - NS'(1))) != '0);
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) begin
          vld_q[s] <= (s == 0) ? in_if.valid : vld_q[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  // ------------------------------------------------------------- entry stage
  logic signed [XY_W-1:0] x_q [NUM_ITER+1];
  logic signed [XY_W-1:0] y_q [NUM_ITER+1];
  logic signed [Z_W-1:0]  z_q [NUM_ITER+1];
  logic                   slow_q [NUM_ITER+2];

  logic signed [MAG_W-1:0] xe, ye, xabs, yabs, xm, xr, yr;
  logic        [MAG_W-1:0] lim;
  logic signed [Z_W-1:0]   z0;
  logic                    slow0;

  always_comb begin
    xe    = MAG_W'(in_if.x_speed);
    ye    = MAG_W'(in_if.y_speed);
    xabs  = xe[MAG_W-1] ? -xe : xe;
    yabs  = ye[MAG_W-1] ? -ye : ye;
    lim   = MAG_W'(min_speed_q);
    slow0 = ($unsigned(xabs) <= lim) && ($unsigned(yabs) <= lim);
    xm    = (in_if.func == FUNC_SIDESLIP) ? xabs : xe;
    xr    = xm;
    yr    = ye;
    z0    = '0;
    // Left half plane: turn a quarter turn into the right half first.
    if (xm[MAG_W-1]) begin
      if (!ye[MAG_W-1]) begin
        xr = ye;
        yr = -xm;
        z0 = QUARTER_TURN;
      end else begin
        xr = -ye;
        yr = xm;
        z0 = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q[0]    <= XY_W'(xr) <<< GUARD_BITS;
      y_q[0]    <= XY_W'(yr) <<< GUARD_BITS;
      z_q[0]    <= z0;
      slow_q[0] <= slow0;
    end
  end

  // -------------------------------------------------------- vectoring stages
  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    logic signed [XY_W-1:0] xsh, ysh;
    logic signed [Z_W-1:0]  step;

    assign xsh  = x_q[i] >>> i;
    assign ysh  = y_q[i] >>> i;
    assign step = Z_W'(ATAN_TAB[i]);

    always_ff @(posedge clk_i) begin
      if (en[i+1]) begin
        slow_q[i+1] <= slow_q[i];
        if (!y_q[i][XY_W-1]) begin
          x_q[i+1] <= x_q[i] + ysh;
          y_q[i+1] <= y_q[i] - xsh;
          z_q[i+1] <= z_q[i] + step;
        end else begin
          x_q[i+1] <= x_q[i] - ysh;
          y_q[i+1] <= y_q[i] + xsh;
          z_q[i+1] <= z_q[i] - step;
        end
      end
    end
  end

  // --------------------------------------------- scaling to Q3.13 radians
  logic signed [PROD_W-1:0] prod_d, prod_q;

  assign prod_d = z_q[NUM_ITER] * PI_Q29;

  always_ff @(posedge clk_i) begin
    if (en[PROD_ST]) begin
      prod_q              <= prod_d;
      slow_q[NUM_ITER+1]  <= slow_q[NUM_ITER];
    end
  end

  logic signed [PROD_W-1:0]  rnd;
  logic signed [RES_W-1:0]   res;
  logic signed [ANGLE_W-1:0] angle_d, angle_q;
  logic                      too_slow_q;

  always_comb begin
    rnd = prod_q + ROUND_ADD;
    res = rnd[PROD_W-1:ROUND_SHIFT];
    if (res > LIM_HI) begin
      angle_d = ANGLE_LIMIT;
    end else if (res < LIM_LO) begin
      angle_d = -ANGLE_LIMIT;
    end else begin
      angle_d = res[ANGLE_W-1:0];
    end
    if (slow_q[NUM_ITER+1]) begin
      angle_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_ST]) begin
      angle_q    <= angle_d;
      too_slow_q <= slow_q[NUM_ITER+1];
    end
  end

  assign out_if.valid    = vld_q[OUT_ST];
  assign out_if.angle    = angle_q;
  assign out_if.too_slow = too_slow_q;

  // -------------------------------------------------------------- assertions
  a_slow_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.too_slow |-> out_if.angle == '0)
    else $error("low speed word with nonzero angle");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.angle <= ANGLE_LIMIT) && (out_if.angle >= -ANGLE_LIMIT))
    else $error("angle outside saturation limits");

  a_turn_right_half : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> !x_q[0][XY_W-1])
    else $error("quadrant turn left x negative");

  a_last_x_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NUM_ITER] |-> !x_q[NUM_ITER][XY_W-1])
    else $error("x went negative during vectoring");

  a_prod_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[PROD_ST] && !en[PROD_ST] |=> vld_q[PROD_ST] && $stable(prod_q))
    else $error("stalled product stage lost its word");

endmodule

`default_nettype wire
